@@ design/ophr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ophr_pkg
// shared types, sizes and helpers for the position history ring
// ----------------------------------------------------------------------------
package ophr_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LEN_W = 6;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [7:0]         size;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic add_en;
        logic read_start;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } stat_t;

    // ring length in use, saturated at the store depth
    function automatic cnt_t sat_len(len_t v);
        if (int'(v) > DEPTH)
        begin
            return cnt_t'(DEPTH);
        end
        return cnt_t'(v);
    endfunction

    // next slot, wrapping at the ring length
    function automatic idx_t advance(idx_t i, cnt_t len);
        cnt_t nxt;
        nxt = cnt_t'(i) + cnt_t'(1);
        return (nxt >= len) ? idx_t'(0) : idx_t'(nxt);
    endfunction

endpackage

@@ design/ophr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ophr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ophr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ophr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ophr_ctrl
// request sequencer: takes adds in place, streams read runs
// ----------------------------------------------------------------------------
module ophr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_kind,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ophr_pkg::stat_t  stat,
    output ophr_pkg::cmd_t   cmd
);

    ophr_pkg::state_t state_reg;
    ophr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ophr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ophr_pkg::ST_IDLE:
            begin
                if (in_valid && in_kind == ophr_pkg::REQ_READ)
                begin
                    state_next = ophr_pkg::ST_SEND;
                end
            end
            ophr_pkg::ST_SEND:
            begin
                if (out_ready && stat.last)
                begin
                    state_next = ophr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ophr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.add_en     = 1'b0;
        cmd.read_start = 1'b0;
        cmd.step       = 1'b0;
        case (state_reg)
            ophr_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.add_en     = in_valid && (in_kind == ophr_pkg::REQ_ADD);
                cmd.read_start = in_valid && (in_kind == ophr_pkg::REQ_READ);
            end
            ophr_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !stat.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/ophr_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ophr_dp
// ring pointers, entry store and read run counters
// ----------------------------------------------------------------------------
module ophr_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  ophr_pkg::len_t       cfg_data,
    input  ophr_pkg::cmd_t       cmd,
    input  ophr_pkg::entry_t     in_entry,
    input  ophr_pkg::len_t       in_limit,
    output ophr_pkg::stat_t      stat,
    output ophr_pkg::entry_t     out_entry,
    output ophr_pkg::len_t       out_count,
    output logic                 out_item_valid
);

    ophr_pkg::cnt_t len_reg,    len_next;
    ophr_pkg::idx_t newest_reg, newest_next;
    ophr_pkg::idx_t oldest_reg, oldest_next;
    ophr_pkg::cnt_t count_reg,  count_next;
    ophr_pkg::idx_t rd_idx_reg, rd_idx_next;
    ophr_pkg::len_t n_reg,      n_next;
    ophr_pkg::len_t sent_reg,   sent_next;

    ophr_pkg::idx_t   wr_idx;
    logic             wr_en;
    logic             rd_en;
    ophr_pkg::idx_t   rd_addr;
    ophr_pkg::entry_t rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            n_reg      <= '0;
            sent_reg   <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            n_reg      <= n_next;
            sent_reg   <= sent_next;
        end
    end

    always_comb
    begin
        len_next    = len_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        n_next      = n_reg;
        sent_next   = sent_reg;
        wr_en       = 1'b0;
        wr_idx      = newest_reg;

        if (cfg_valid)
        begin
            // new length empties the ring
            len_next    = ophr_pkg::sat_len(cfg_data);
            newest_next = '0;
            oldest_next = '0;
            count_next  = '0;
        end
        else if (cmd.add_en && len_reg != '0)
        begin
            wr_en = 1'b1;
            if (count_reg == '0)
            begin
                wr_idx      = (ophr_pkg::cnt_t'(newest_reg) >= len_reg) ? '0 : newest_reg;
                newest_next = wr_idx;
                oldest_next = wr_idx;
                count_next  = ophr_pkg::cnt_t'(1);
            end
            else
            begin
                wr_idx      = ophr_pkg::advance(newest_reg, len_reg);
                newest_next = wr_idx;
                if (wr_idx == oldest_reg)
                begin
                    // full: drop the oldest
                    oldest_next = ophr_pkg::advance(oldest_reg, len_reg);
                    count_next  = len_reg;
                end
                else
                begin
                    count_next = count_reg + ophr_pkg::cnt_t'(1);
                end
            end
        end

        if (cmd.read_start)
        begin
            n_next      = (int'(in_limit) < int'(count_reg)) ? in_limit
                                                              : ophr_pkg::len_t'(count_reg);
            sent_next   = '0;
            rd_idx_next = ophr_pkg::advance(oldest_reg, len_reg);
        end
        else if (cmd.step)
        begin
            sent_next   = sent_reg + ophr_pkg::len_t'(1);
            rd_idx_next = ophr_pkg::advance(rd_idx_reg, len_reg);
        end
    end

    assign rd_en   = cmd.read_start || cmd.step;
    assign rd_addr = cmd.read_start ? oldest_reg : rd_idx_reg;

    ophr_ram #(
        .WIDTH ($bits(ophr_pkg::entry_t)),
        .DEPTH (ophr_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_item_valid = (n_reg != '0);
    assign out_count      = n_reg;
    assign out_entry      = out_item_valid ? rd_data : '0;
    assign stat.last      = !out_item_valid || ((sent_reg + ophr_pkg::len_t'(1)) == n_reg);

endmodule

@@ design/overwriting_position_history_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_position_history_ring
// history ring of positions, oldest entry overwritten when full
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata position + limit, tuser kind
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata entry + count, tuser valid, tlast
//  cfg       in         cfg_valid/cfg_ready          cfg_data ring length
//
//  an add request is taken at its handshake and the next request can follow at once
//  a read request starts a run that streams one entry per cycle, unless the output stalls,
//  from the registered read port of the entry store; input is held off until its run ends
//  a read that finds nothing gives a single result with tuser low and tlast high
//  reset clears the length and pointers; the entry store itself is not cleared
//  an output stall simply holds the current result and the read address
//
module overwriting_position_history_ring (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, pos_size, read_limit, zero pad
    input  logic [0:0]  s_axis_tuser,   // req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_x, out_y, out_size, returned_count, zero pad
    output logic [0:0]  m_axis_tuser,   // item_valid
    output logic        m_axis_tlast,
    // ring length register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    ophr_pkg::cmd_t   cmd;
    ophr_pkg::stat_t  stat;
    ophr_pkg::entry_t in_entry;
    ophr_pkg::entry_t out_entry;
    ophr_pkg::len_t   out_count;
    logic             out_item_valid;

    // length writes must only arrive while idle; the block does not enforce this and is always ready
    assign cfg_ready = 1'b1;

    // unpack the request
    assign in_entry.x    = s_axis_tdata[15:0];
    assign in_entry.y    = s_axis_tdata[31:16];
    assign in_entry.size = s_axis_tdata[39:32];

    ophr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ophr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .in_entry       (in_entry),
        .in_limit       (s_axis_tdata[45:40]),
        .stat           (stat),
        .out_entry      (out_entry),
        .out_count      (out_count),
        .out_item_valid (out_item_valid)
    );

    // pack the result
    assign m_axis_tdata[15:0]  = out_entry.x;
    assign m_axis_tdata[31:16] = out_entry.y;
    assign m_axis_tdata[39:32] = out_entry.size;
    assign m_axis_tdata[45:40] = out_count;
    assign m_axis_tdata[47:46] = 2'b00;
    assign m_axis_tuser[0]     = out_item_valid;
    assign m_axis_tlast        = stat.last;

endmodule

@@ bench/ophr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ophr_checker
// scoreboard for the position history ring: watches the request, result and
// ring length channels, keeps its own copy of the ring and compares every
// result beat with the oldest expected beat
// ----------------------------------------------------------------------------
module ophr_checker
    import ophr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, pos_size, read_limit, zero pad
    input  logic [0:0]  s_axis_tuser,   // req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // out_x, out_y, out_size, returned_count, zero pad
    input  logic [0:0]  m_axis_tuser,   // item_valid
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         size;
        len_t               count;
        logic               item_valid;
        logic               tail;
    } history_beat_t;

    entry_t        ring_mem [DEPTH];
    int unsigned   newest_slot = 0;
    int unsigned   oldest_slot = 0;
    int unsigned   held = 0;
    int unsigned   len_in_use = 0;
    history_beat_t expected_beats [$];

    function automatic int unsigned wrap_next(int unsigned i);
        return (i + 1 >= len_in_use) ? 0 : i + 1;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // add stores after the newest entry, read lists the oldest entries
    task automatic history_apply(logic kind, logic signed [15:0] x, logic signed [15:0] y,
                                 logic [7:0] sz, len_t lim);
        entry_t        e;
        int unsigned   n;
        int unsigned   idx;
        history_beat_t b;
        if (kind == REQ_ADD)
        begin
            if (len_in_use == 0)
            begin
                return;
            end
            e.x    = x;
            e.y    = y;
            e.size = sz;
            if (held == 0)
            begin
                if (newest_slot >= len_in_use)
                begin
                    newest_slot = 0;
                end
                oldest_slot           = newest_slot;
                ring_mem[newest_slot] = e;
                held                  = 1;
            end
            else
            begin
                newest_slot           = wrap_next(newest_slot);
                ring_mem[newest_slot] = e;
                if (newest_slot == oldest_slot)
                begin
                    // full ring, oldest entry overwritten
                    oldest_slot = wrap_next(oldest_slot);
                    held        = len_in_use;
                end
                else
                begin
                    held++;
                end
            end
        end
        else
        begin
            n = (lim < held) ? lim : held;
            if (n == 0)
            begin
                b = '{x: '0, y: '0, size: '0, count: '0, item_valid: 1'b0, tail: 1'b1};
                expected_beats.push_back(b);
            end
            else
            begin
                idx = oldest_slot;
                for (int unsigned k = 0; k < n; k++)
                begin
                    b.x          = ring_mem[idx].x;
                    b.y          = ring_mem[idx].y;
                    b.size       = ring_mem[idx].size;
                    b.count      = len_t'(n);
                    b.item_valid = 1'b1;
                    b.tail       = (k + 1 == n);
                    expected_beats.push_back(b);
                    idx = wrap_next(idx);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        history_beat_t b;
        if (!rst_n)
        begin
            len_in_use  = 0;
            newest_slot = 0;
            oldest_slot = 0;
            held        = 0;
            expected_beats.delete();
        end
        else
        begin
            // results first: a request taken at this edge cannot answer at it
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("result with no read outstanding");
                end
                else
                begin
                    b = expected_beats.pop_front();
                    check_field("out_x", $signed(m_axis_tdata[15:0]), b.x);
                    check_field("out_y", $signed(m_axis_tdata[31:16]), b.y);
                    check_field("out_size", m_axis_tdata[39:32], b.size);
                    check_field("returned_count", m_axis_tdata[45:40], b.count);
                    check_field("item_valid", m_axis_tuser[0], b.item_valid);
                    check_field("last", m_axis_tlast, b.tail);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                len_in_use  = (cfg_data > DEPTH) ? DEPTH : cfg_data;
                newest_slot = 0;
                oldest_slot = 0;
                held        = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                history_apply(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16],
                              s_axis_tdata[39:32], s_axis_tdata[45:40]);
            end
        end
        pending = expected_beats.size();
    end

endmodule

@@ bench/tb_overwriting_position_history_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_position_history_ring
// drives add and read requests into the position history ring under several
// ring lengths, with random gaps on both streams and one long output stall;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_overwriting_position_history_ring;
    import ophr_pkg::*;

    // cycles with no handshake at all before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    // output hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;
    // quiet cycles after the last result, covers an add still in flight
    localparam int SETTLE = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // pos_x, pos_y, pos_size, read_limit, zero pad
    logic [0:0]  s_axis_tuser = '0;     // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // out_x, out_y, out_size, returned_count, zero pad
    logic [0:0]  m_axis_tuser;          // item_valid
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;

    int fail_count;
    int pending;

    // phase controls for the two stream drivers
    bit fast_phase = 1'b0;      // no gaps on either side
    bit hold_pending = 1'b0;    // ask the result sink for its long stall

    int idle_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    overwriting_position_history_ring u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    ophr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n ||
            (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("overwriting_position_history_ring test failed");
                $finish;
            end
        end
    end

    // result sink: random hold-off before each result, one long stall on request
    initial
    begin : result_sink
        int  gap;
        bit  hold_taken;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_pending && !hold_taken)
            begin
                // long stall, the sender keeps offering so the block backs up
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = fast_phase ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
            begin
                @(posedge clk);
            end
        end
    end

    // one request on the input stream; valid stays up between back-to-back requests
    task automatic send_req(logic kind, logic signed [15:0] x, logic signed [15:0] y,
                            logic [7:0] sz, len_t lim);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, lim, sz, y, x};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding result, then let an add settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // ring length write, only ever issued from an idle block
    task automatic set_ring_length(len_t v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic len_t pick_limit();
        case ($urandom_range(0, 3))
            0:       return len_t'(32);
            1:       return len_t'($urandom_range(0, 3));
            default: return len_t'($urandom_range(0, 32));
        endcase
    endfunction

    // one random phase at a given ring length, adds weighted by add_pct
    task automatic run_phase(len_t len, int n_items, int add_pct, bit fast);
        logic kind;
        drain();
        set_ring_length(len);
        fast_phase = fast;
        for (int i = 0; i < n_items; i++)
        begin
            kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_READ;
            send_req(kind, 16'($urandom), 16'($urandom), 8'($urandom), pick_limit());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ring length zero straight out of reset: reads find nothing, adds vanish
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(5));
        send_req(REQ_ADD, 16'sd123, -16'sd45, 8'd9, len_t'(0));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(32));

        // short ring: coordinate extremes, zero limit, partial read, overwrite
        drain();
        set_ring_length(len_t'(4));
        send_req(REQ_ADD, -16'sd32768, 16'sd32767, 8'd0, len_t'(0));
        send_req(REQ_ADD, 16'sd32767, -16'sd32768, 8'd255, len_t'(63));
        send_req(REQ_ADD, 16'sd0, -16'sd1, 8'hAA, len_t'(0));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(0));
        send_req(REQ_READ, -16'sd1, -16'sd1, 8'hFF, len_t'(2));
        send_req(REQ_ADD, -16'sd1, 16'sd0, 8'h55, len_t'(0));
        send_req(REQ_ADD, 16'sd1, 16'sd1, 8'd1, len_t'(0));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(32));

        // length above the store depth saturates, all register bits set
        drain();
        set_ring_length(len_t'(63));
        send_req(REQ_ADD, 16'sh5A5A, 16'shA5A5, 8'h0F, len_t'(0));
        send_req(REQ_ADD, 16'shA5A5, 16'sh5A5A, 8'hF0, len_t'(0));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(31));

        // single-entry ring, every add replaces the one entry
        drain();
        set_ring_length(len_t'(1));
        send_req(REQ_ADD, 16'sd7, 16'sd8, 8'd9, len_t'(0));
        send_req(REQ_ADD, 16'sd10, 16'sd11, 8'd12, len_t'(0));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(1));
        send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(32));

        // random phases
        run_phase(len_t'(3), 20, 70, 1'b0);
        run_phase(len_t'(32), 45, 90, 1'b1);

        // full ring of 32, then long reads against a stalled output
        fast_phase   = 1'b0;
        hold_pending = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 3 == 2)
            begin
                send_req(REQ_ADD, 16'($urandom), 16'($urandom), 8'($urandom), len_t'(0));
            end
            else
            begin
                send_req(REQ_READ, 16'sd0, 16'sd0, 8'd0, len_t'(32));
            end
        end

        run_phase(len_t'(1), 12, 60, 1'b0);
        run_phase(len_t'(0), 8, 50, 1'b0);
        run_phase(len_t'(45), 25, 75, 1'b0);
        run_phase(len_t'(17), 25, 70, 1'b1);
        run_phase(len_t'(2), 15, 60, 1'b0);

        drain();
        repeat (16) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("overwriting_position_history_ring test passed");
        end
        else
        begin
            $display("overwriting_position_history_ring test failed");
        end
        $finish;
    end

endmodule

@@ overwriting_position_history_ring.f @@
design/ophr_pkg.sv
design/ophr_ram.sv
design/ophr_ctrl.sv
design/ophr_dp.sv
design/overwriting_position_history_ring.sv
bench/ophr_checker.sv
bench/tb_overwriting_position_history_ring.sv
